// ===== rtl/framed_xor_autokey_codec_top_assert.svh =====
// assertion macros shared by the codec modules
`ifndef FRAMED_XOR_AUTOKEY_CODEC_TOP_ASSERT_SVH
`define FRAMED_XOR_AUTOKEY_CODEC_TOP_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define FXAC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// condition must hold in the cycle after the trigger
`define FXAC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/fxac_pkg.sv =====
// shared types and constants of the framed xor autokey codec
package fxac_pkg;

  // frame length limit and derived widths
  localparam int unsigned MAX_FRAME = 1024;
  localparam int unsigned DLEN_W    = $clog2(MAX_FRAME);

  // reset value of the key register
  localparam logic [7:0] INIT_KEY_RST = 8'hAB;

  // command codes
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_ENC   = 2'd1;
  localparam logic [1:0] CMD_RECV  = 2'd2;
  localparam logic [1:0] CMD_ABORT = 2'd3;

  // result kinds
  localparam logic [2:0] KIND_HDR     = 3'd0;
  localparam logic [2:0] KIND_CIPHER  = 3'd1;
  localparam logic [2:0] KIND_PLAIN   = 3'd2;
  localparam logic [2:0] KIND_EMPTY   = 3'd3;
  localparam logic [2:0] KIND_LEN_ERR = 3'd4;

  // header expansion
  localparam int unsigned HDR_BEATS     = 4;
  localparam logic [1:0]  HDR_LAST_BEAT = 2'(HDR_BEATS - 1);
  localparam logic [2:0]  HDR_DONE      = 3'(HDR_BEATS);

  // queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // input beat
  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data_in;
    logic [9:0] msg_len;
  } in_beat_t;

  // result beat
  typedef struct packed {
    logic [7:0] data_out;
    logic [2:0] kind;
    logic       last;
  } out_beat_t;

  // queued operation; a header entry holds the length in len_hi and data
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic [1:0] len_hi;
    logic       last;
  } q_entry_t;

  // write side of the queue
  typedef struct packed {
    logic     push;
    q_entry_t entry;
  } q_wr_t;

endpackage

// ===== rtl/fxac_front.sv =====
// front end: takes input beats, keeps cipher state, queues result operations
module fxac_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  fxac_pkg::in_beat_t in_data,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data,
  input  logic               q_full,
  output fxac_pkg::q_wr_t    q_wr
);
  import fxac_pkg::*;

  logic [7:0]        init_key_r;
  logic [7:0]        enc_key_r, enc_key_nxt;
  logic [9:0]        enc_rem_r, enc_rem_nxt;
  logic [7:0]        dec_key_r, dec_key_nxt;
  logic [2:0]        hdr_cnt_r, hdr_cnt_nxt;
  logic [31:0]       decl_r, decl_nxt;
  logic [DLEN_W-1:0] dec_rem_r, dec_rem_nxt;
  logic              accept;
  logic [31:0]       decl_shift;
  logic [7:0]        xor_byte;

  assign in_ready   = !q_full;
  assign accept     = in_valid && in_ready;
  assign decl_shift = {decl_r[23:0], in_data.data_in};

  // classify the beat and work out the state update
  always_comb begin
    enc_key_nxt = enc_key_r;
    enc_rem_nxt = enc_rem_r;
    dec_key_nxt = dec_key_r;
    hdr_cnt_nxt = hdr_cnt_r;
    decl_nxt    = decl_r;
    dec_rem_nxt = dec_rem_r;
    q_wr        = '0;
    xor_byte    = '0;
    if (accept) begin
      case (in_data.cmd)
        CMD_START: begin
          enc_key_nxt       = init_key_r;
          enc_rem_nxt       = in_data.msg_len;
          q_wr.push         = 1'b1;
          q_wr.entry.kind   = KIND_HDR;
          q_wr.entry.data   = in_data.msg_len[7:0];
          q_wr.entry.len_hi = in_data.msg_len[9:8];
          q_wr.entry.last   = (in_data.msg_len == 10'd0);
        end
        CMD_ENC: begin
          // ignored when no frame is open
          if (enc_rem_r != 10'd0) begin
            xor_byte        = enc_key_r ^ in_data.data_in;
            enc_key_nxt     = xor_byte;
            enc_rem_nxt     = enc_rem_r - 10'd1;
            q_wr.push       = 1'b1;
            q_wr.entry.kind = KIND_CIPHER;
            q_wr.entry.data = xor_byte;
            q_wr.entry.last = (enc_rem_r == 10'd1);
          end
        end
        CMD_RECV: begin
          if (hdr_cnt_r != HDR_DONE) begin
            // length header, big-endian
            decl_nxt    = decl_shift;
            hdr_cnt_nxt = hdr_cnt_r + 3'd1;
            if (hdr_cnt_r == HDR_DONE - 3'd1) begin
              if (decl_shift == 32'd0) begin
                hdr_cnt_nxt     = '0;
                dec_rem_nxt     = '0;
                q_wr.push       = 1'b1;
                q_wr.entry.kind = KIND_EMPTY;
                q_wr.entry.last = 1'b1;
              end else if (decl_shift >= 32'(MAX_FRAME)) begin
                hdr_cnt_nxt     = '0;
                dec_rem_nxt     = '0;
                q_wr.push       = 1'b1;
                q_wr.entry.kind = KIND_LEN_ERR;
              end else begin
                dec_rem_nxt = decl_shift[DLEN_W-1:0];
                dec_key_nxt = init_key_r;
              end
            end
          end else begin
            // frame body
            xor_byte        = dec_key_r ^ in_data.data_in;
            dec_key_nxt     = in_data.data_in;
            q_wr.push       = 1'b1;
            q_wr.entry.kind = KIND_PLAIN;
            q_wr.entry.data = xor_byte;
            if (dec_rem_r <= DLEN_W'(1)) begin
              q_wr.entry.last = 1'b1;
              hdr_cnt_nxt     = '0;
              dec_rem_nxt     = '0;
            end else begin
              dec_rem_nxt = dec_rem_r - DLEN_W'(1);
            end
          end
        end
        CMD_ABORT: begin
          hdr_cnt_nxt = '0;
          dec_rem_nxt = '0;
          decl_nxt    = '0;
          dec_key_nxt = init_key_r;
        end
        default: begin
          hdr_cnt_nxt = hdr_cnt_r;
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_key_r <= INIT_KEY_RST;
      enc_key_r  <= INIT_KEY_RST;
      enc_rem_r  <= '0;
      dec_key_r  <= INIT_KEY_RST;
      hdr_cnt_r  <= '0;
      decl_r     <= '0;
      dec_rem_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        init_key_r <= cfg_wr_data;
      end
      enc_key_r <= enc_key_nxt;
      enc_rem_r <= enc_rem_nxt;
      dec_key_r <= dec_key_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
      decl_r    <= decl_nxt;
      dec_rem_r <= dec_rem_nxt;
    end
  end

endmodule

// ===== rtl/fxac_queue.sv =====
// short queue of result operations between front and back
`include "framed_xor_autokey_codec_top_assert.svh"
module fxac_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  fxac_pkg::q_wr_t    q_wr,
  output logic               q_full,
  input  logic               pop,
  output logic               q_valid,
  output fxac_pkg::q_entry_t q_head
);
  import fxac_pkg::*;

  q_entry_t          slots_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push;

  assign push    = q_wr.push;
  assign q_full  = (count_r == QCNT_W'(QDEPTH));
  assign q_valid = (count_r != '0);
  assign q_head  = slots_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= q_wr.entry;
    end
  end

  `FXAC_ASSERT_SAME(a_no_overflow, push, !q_full, "queue written while full")
  `FXAC_ASSERT_SAME(a_no_underflow, pop, q_valid, "queue read while empty")
  `FXAC_ASSERT_NEXT(a_fill_up, push && !pop, count_r == $past(count_r) + QCNT_W'(1), "fill count")

endmodule

// ===== rtl/fxac_back.sv =====
// back end: expands queued operations into result beats, output register
`include "framed_xor_autokey_codec_top_assert.svh"
module fxac_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  fxac_pkg::q_entry_t  q_head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output fxac_pkg::out_beat_t out_data
);
  import fxac_pkg::*;

  logic      out_valid_r, out_valid_nxt;
  out_beat_t out_r, out_nxt;
  logic [1:0] beat_r, beat_nxt;
  logic       load_ok;
  logic       emit;
  logic       is_hdr;

  assign load_ok = !out_valid_r || out_ready;
  assign emit    = q_valid && load_ok;
  assign is_hdr  = (q_head.kind == KIND_HDR);
  assign pop     = emit && (!is_hdr || beat_r == HDR_LAST_BEAT);

  // pick the next result beat
  always_comb begin
    out_nxt       = out_r;
    beat_nxt      = beat_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_nxt.kind  = q_head.kind;
      out_nxt.data_out = q_head.data;
      out_nxt.last  = q_head.last;
      if (is_hdr) begin
        // header: two zero bytes, then the length high and low
        case (beat_r)
          2'd0, 2'd1: out_nxt.data_out = 8'h00;
          2'd2:       out_nxt.data_out = {6'b0, q_head.len_hi};
          default:    out_nxt.data_out = q_head.data;
        endcase
        out_nxt.last = q_head.last && (beat_r == HDR_LAST_BEAT);
        beat_nxt     = (beat_r == HDR_LAST_BEAT) ? 2'd0 : beat_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      beat_r      <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      beat_r      <= beat_nxt;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `FXAC_ASSERT_SAME(a_beat_in_hdr, beat_r != 2'd0, q_valid && is_hdr, "stray header beat")
  `FXAC_ASSERT_SAME(a_pop_loads, pop, load_ok, "entry dropped without output load")
  `FXAC_ASSERT_NEXT(a_emit_shows, emit, out_valid_r, "emitted beat not presented")

endmodule

// ===== rtl/framed_xor_autokey_codec_top.sv =====
// Framed xor autokey codec, top level.
// A taken beat is queued, then its first result is loaded into the output register.
// Throughput: one input beat per cycle while the queue has room; each beat gives at most one
// result beat, except an encrypt start, which gives four header beats.
// The output port is the rate limit; a four-entry queue sits between front and back.
// Reset: synchronous active-low rst_n clears both sides and reloads the key to 0xAB.
module framed_xor_autokey_codec_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  fxac_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output fxac_pkg::out_beat_t out_data,
  input  logic                cfg_wr_en,
  input  logic [7:0]          cfg_wr_data
);
  import fxac_pkg::*;

  q_wr_t    q_wr;
  q_entry_t q_head;
  logic     q_full;
  logic     q_valid;
  logic     pop;

  // input side: cipher state and classification
  fxac_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_full      (q_full),
    .q_wr        (q_wr)
  );

  // decoupling queue
  fxac_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_wr    (q_wr),
    .q_full  (q_full),
    .pop     (pop),
    .q_valid (q_valid),
    .q_head  (q_head)
  );

  // output side: header expansion and result register
  fxac_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== tb/framed_xor_autokey_codec_top_test.sv =====
// testbench of the framed xor autokey codec: directed and random beats checked against a model
module framed_xor_autokey_codec_top_test;
  import fxac_pkg::*;

  localparam int unsigned RANDOM_BEATS  = 250;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT   = 200000;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  in_beat_t   in_data;
  logic       out_valid;
  logic       out_ready;
  out_beat_t  out_data;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;

  // mirror of the codec state
  logic [7:0]        key_reg;
  logic [7:0]        enc_key_m;
  logic [9:0]        enc_left;
  logic [7:0]        dec_key_m;
  logic [2:0]        hdr_seen;
  logic [31:0]       frame_len;
  logic [DLEN_W-1:0] dec_left;

  // result beats still owed by the codec, oldest first
  out_beat_t codec_out_q[$];

  int unsigned fail_cnt;
  int unsigned beats_sent;
  int unsigned counted_beats;
  int unsigned results_seen;
  int unsigned key_writes;
  int unsigned cycle_cnt;
  int unsigned sink_wait;
  bit          gaps_on;

  always #5 clk = ~clk;

  framed_xor_autokey_codec_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[framed_xor_autokey_codec_top] ERROR");
      $finish;
    end
  end

  function automatic void push_result(input logic [7:0] d, input logic [2:0] k,
                                      input logic l);
    out_beat_t r;
    r.data_out = d;
    r.kind     = k;
    r.last     = l;
    codec_out_q.push_back(r);
  endfunction

  function automatic void clear_rx();
    hdr_seen  = '0;
    frame_len = '0;
    dec_left  = '0;
    dec_key_m = key_reg;
  endfunction

  // advance the mirrored codec by one accepted input beat
  function automatic void codec_step(input in_beat_t b);
    logic [7:0] c;
    logic       fin;
    if (!(b.cmd == CMD_ENC && enc_left == 0)) counted_beats++;
    case (b.cmd)
      CMD_START: begin
        enc_key_m = key_reg;
        enc_left  = b.msg_len;
        push_result(8'h00, KIND_HDR, 1'b0);
        push_result(8'h00, KIND_HDR, 1'b0);
        push_result({6'd0, b.msg_len[9:8]}, KIND_HDR, 1'b0);
        push_result(b.msg_len[7:0], KIND_HDR, b.msg_len == 10'd0);
      end
      CMD_ENC: begin
        // nothing happens with no frame open
        if (enc_left != 0) begin
          c = enc_key_m ^ b.data_in;
          enc_key_m = c;
          enc_left--;
          push_result(c, KIND_CIPHER, enc_left == 0);
        end
      end
      CMD_ABORT: clear_rx();
      CMD_RECV: begin
        if (hdr_seen < HDR_DONE) begin
          // big-endian length header, no result until it is complete
          frame_len = {frame_len[23:0], b.data_in};
          hdr_seen++;
          if (hdr_seen == HDR_DONE) begin
            if (frame_len == 32'd0) begin
              clear_rx();
              push_result(8'h00, KIND_EMPTY, 1'b1);
            end else if (frame_len >= MAX_FRAME) begin
              clear_rx();
              push_result(8'h00, KIND_LEN_ERR, 1'b0);
            end else begin
              dec_left  = frame_len[DLEN_W-1:0];
              dec_key_m = key_reg;
            end
          end
        end else begin
          c = dec_key_m ^ b.data_in;
          dec_key_m = b.data_in;
          if (dec_left != 0) dec_left--;
          fin = (dec_left == 0);
          push_result(c, KIND_PLAIN, fin);
          if (fin) clear_rx();
        end
      end
      default: ;
    endcase
  endfunction

  // compare each result beat with the oldest one owed
  always @(posedge clk) begin : check_results
    out_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (codec_out_q.size() == 0) begin
        $error("result beat with none owed: data_out %02h kind %0d last %0b",
               out_data.data_out, out_data.kind, out_data.last);
        fail_cnt++;
      end else begin
        want = codec_out_q.pop_front();
        if (out_data.data_out !== want.data_out) begin
          $error("data_out: expected %02h, got %02h", want.data_out, out_data.data_out);
          fail_cnt++;
        end
        if (out_data.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_data.kind);
          fail_cnt++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_data.last);
          fail_cnt++;
        end
      end
      sink_wait = gaps_on ? $urandom_range(0, 3) : 0;
    end
  end

  // receiver may stall after each beat while gaps are on
  always @(negedge clk) begin
    if (sink_wait != 0) begin
      out_ready <= 1'b0;
      sink_wait--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // present one input beat and wait until it is taken
  task automatic send_cmd(input logic [1:0] cmd, input logic [7:0] data,
                          input logic [9:0] len);
    int unsigned gap;
    in_beat_t    b;
    b.cmd     = cmd;
    b.data_in = data;
    b.msg_len = len;
    gap = gaps_on ? $urandom_range(0, 3) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    codec_step(b);
    beats_sent++;
  endtask

  task automatic send_header(input logic [31:0] len);
    for (int i = 3; i >= 0; i--) send_cmd(CMD_RECV, len[8*i +: 8], 10'($urandom_range(0, 1023)));
  endtask

  // hold the sender until every owed beat is in, then let the pipeline settle
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (codec_out_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_key(input logic [7:0] k);
    drain_results();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= k;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    key_reg = k;
    key_writes++;
  endtask

  task automatic test_encrypt_directed();
    gaps_on = 1'b1;
    // empty frame: last on the final header beat
    send_cmd(CMD_START, 8'h00, 10'd0);
    // no frame open, ignored
    send_cmd(CMD_ENC, 8'h3C, 10'h3FF);
    // widest frame, left open
    send_cmd(CMD_START, 8'hFF, 10'h3FF);
    send_cmd(CMD_ENC, 8'h00, 10'd0);
    send_cmd(CMD_ENC, 8'hFF, 10'h3FF);
    // new start abandons the open frame
    send_cmd(CMD_START, 8'h5A, 10'd2);
    send_cmd(CMD_ENC, 8'hA5, 10'd0);
    send_cmd(CMD_ENC, 8'h5A, 10'd0);
    // frame complete, ignored
    send_cmd(CMD_ENC, 8'hFF, 10'd0);
  endtask

  task automatic test_decrypt_directed();
    send_header(32'd0);
    // length error right at the limit
    send_header(MAX_FRAME);
    // longest legal frame, aborted mid-payload
    send_header(MAX_FRAME - 1);
    send_cmd(CMD_RECV, 8'hFF, 10'd0);
    send_cmd(CMD_ABORT, 8'hFF, 10'h3FF);
    send_header(32'd1);
    send_cmd(CMD_RECV, 8'h00, 10'd0);
  endtask

  task automatic test_key_writes();
    logic [7:0] keys [3];
    keys[0] = 8'h00;
    keys[1] = 8'hFF;
    keys[2] = 8'($urandom);
    foreach (keys[i]) begin
      write_key(keys[i]);
      send_cmd(CMD_START, 8'($urandom), 10'd3);
      repeat (3) send_cmd(CMD_ENC, 8'($urandom), 10'($urandom));
      send_header(32'd2);
      repeat (2) send_cmd(CMD_RECV, 8'($urandom), 10'($urandom));
    end
    // a write inside an open frame only reaches the next frame
    send_cmd(CMD_START, 8'($urandom), 10'd4);
    repeat (2) send_cmd(CMD_ENC, 8'($urandom), 10'($urandom));
    write_key(8'($urandom));
    repeat (2) send_cmd(CMD_ENC, 8'($urandom), 10'($urandom));
    send_cmd(CMD_START, 8'($urandom), 10'd1);
    send_cmd(CMD_ENC, 8'($urandom), 10'($urandom));
  endtask

  task automatic test_random_traffic();
    int unsigned goal;
    int unsigned pick;
    int unsigned n;
    int unsigned k;
    int unsigned seq_no;
    logic [31:0] len;
    goal   = counted_beats + RANDOM_BEATS;
    seq_no = 0;
    while (counted_beats < goal) begin
      gaps_on = ($urandom_range(0, 4) != 0);
      pick    = $urandom_range(0, 9);
      if (pick < 4) begin
        // encrypt frame, long ones stay open
        n = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 12) : $urandom_range(0, 1023);
        send_cmd(CMD_START, 8'($urandom), 10'(n));
        k = (n > 12) ? $urandom_range(0, 12) : n;
        for (int i = 0; i < k; i++) send_cmd(CMD_ENC, 8'($urandom), 10'($urandom));
        if ($urandom_range(0, 4) == 0) send_cmd(CMD_ENC, 8'($urandom), 10'($urandom));
      end else if (pick < 8) begin
        pick = $urandom_range(0, 19);
        if (pick == 19) begin
          // header cut short by an abort
          repeat ($urandom_range(1, 3)) send_cmd(CMD_RECV, 8'($urandom), 10'($urandom));
          send_cmd(CMD_ABORT, 8'($urandom), 10'($urandom));
        end else begin
          if (pick < 13) len = $urandom_range(1, 12);
          else if (pick < 15) len = 32'd0;
          else if (pick < 17) len = $urandom_range(32'hFFFF_FFFF, MAX_FRAME);
          else len = $urandom_range(1, MAX_FRAME - 1);
          send_header(len);
          if (len != 0 && len < MAX_FRAME) begin
            k = (len > 12) ? $urandom_range(0, 12) : len;
            if ($urandom_range(0, 6) == 0) k = $urandom_range(0, k);
            for (int i = 0; i < k; i++) send_cmd(CMD_RECV, 8'($urandom), 10'($urandom));
            if (k < len) send_cmd(CMD_ABORT, 8'($urandom), 10'($urandom));
          end
        end
      end else begin
        // noise
        repeat ($urandom_range(1, 4)) begin
          send_cmd(2'($urandom_range(0, 3)), 8'($urandom), 10'($urandom));
        end
      end
      seq_no++;
      if (seq_no == 10) drain_results();
      else if (seq_no % 16 == 0) write_key(8'($urandom));
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_ready   = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    sink_wait   = 0;
    gaps_on     = 1'b1;
    fail_cnt      = 0;
    beats_sent    = 0;
    counted_beats = 0;
    results_seen  = 0;
    key_writes    = 0;
    cycle_cnt     = 0;
    key_reg   = INIT_KEY_RST;
    enc_key_m = INIT_KEY_RST;
    enc_left  = '0;
    clear_rx();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_encrypt_directed();
    test_decrypt_directed();
    test_key_writes();
    test_random_traffic();
    drain_results();

    $display("run covered %0d input beats, %0d result beats and %0d key writes",
             beats_sent, results_seen, key_writes);
    $display("frames both ways, empty, over-length, aborted and abandoned; %0d mismatches",
             fail_cnt);
    if (fail_cnt == 0) begin
      $display("[framed_xor_autokey_codec_top] OK");
    end else begin
      $display("[framed_xor_autokey_codec_top] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/fxac_pkg.sv
rtl/fxac_front.sv
rtl/fxac_queue.sv
rtl/fxac_back.sv
rtl/framed_xor_autokey_codec_top.sv
tb/framed_xor_autokey_codec_top_test.sv
